>>> hdl/wrdf_pkg.sv
// Shared types, constants and action codes for the receive duplicate/defrag filter.
package wrdf_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Field widths and fixed values
	localparam int          ADDR_W    = 48;
	localparam int          TID_W     = 4;
	localparam int          SEQ_W     = 16;
	localparam int          FRAG_W    = 4;
	localparam int          CNT_W     = 5;
	localparam int          LINK_W    = 4;
	localparam int          ACT_W     = 3;
	localparam int          OIDX_W    = 4;
	localparam int          GROUP_BIT = 40;
	localparam logic [SEQ_W-1:0] SEQ_FRESH = 16'hFFFF;
	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd16;

	// Decision codes
	localparam logic [ACT_W-1:0] ACT_DUP    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_OOO    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_MIDDLE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SINGLE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DONE   = 3'd5;

	// One received frame header
	typedef struct packed {
		logic [ADDR_W-1:0] transmitter_addr;
		logic [ADDR_W-1:0] receiver_addr;
		logic [ADDR_W-1:0] amsdu_dest_addr;
		logic              is_qos_data;
		logic              is_amsdu;
		logic [TID_W-1:0]  traffic_id;
		logic              retry_bit;
		logic              more_fragments;
		logic [SEQ_W-1:0]  seq_control;
		logic [LINK_W-1:0] link_id;
	} hdr_t;

	// One decision
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [OIDX_W-1:0] entry_index;
		logic [CNT_W-1:0]  fragment_count;
		logic              table_full;
		logic [LINK_W-1:0] link_out;
	} res_t;

	// Per-originator reassembly state
	typedef struct packed {
		logic [SEQ_W-1:0] last_seq;
		logic             reasm;
		logic [CNT_W-1:0] frag_count;
	} frag_state_t;

	// One stored table entry
	typedef struct packed {
		logic              is_qos;
		logic [ADDR_W-1:0] addr;
		logic [TID_W-1:0]  tid;
		frag_state_t       frag;
	} entry_t;

endpackage

>>> hdl/wlan_rx_duplicate_defrag_filter.sv
// Top level of the 802.11 receive duplicate filter and defragmentation tracker.
// Each accepted frame header is matched against a table of TABLE_ENTRIES originator
// entries by one comparator that walks the entry memory through its single read
// port, one entry per cycle. A frame passes through the scan, a last compare and
// the decide state before its decision is registered, and the next header is taken
// only after the previous decision has been committed; hdr_ready is low while a
// frame is in work and while a finished decision waits for a free output register.
// Unknown originators claim the lowest free entry; when none is left the frame is
// judged against a fresh, unstored entry and table_full is set.
module wlan_rx_duplicate_defrag_filter import wrdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic hdr_valid,
	output logic hdr_ready,
	input  hdr_t hdr,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SCAN    = 2'd1;
	localparam logic [1:0] ST_LASTCMP = 2'd2;
	localparam logic [1:0] ST_DECIDE  = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [1:0]         state_q;
	hdr_t               hdr_q;
	logic [ADDR_W-1:0]  key_addr_q;
	logic [TID_W-1:0]   key_tid_q;
	logic [ADDR_W-1:0]  key_addr_d;
	logic [TID_W-1:0]   key_tid_d;
	logic               rx_group;

	logic [IDX_W-1:0]   rd_idx_q;
	logic               cmp_en_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	entry_t             rd_data;
	logic               rd_valid;
	logic               hit;

	logic               found_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [IDX_W-1:0]   free_idx_q;
	frag_state_t        hit_frag_q;

	logic               full;
	logic [IDX_W-1:0]   sel_idx;
	logic [IDX_W+3:0]   sel_idx_ext;
	frag_state_t        cur_frag;
	frag_state_t        nxt_frag;
	logic [ACT_W-1:0]   action;
	logic               out_free;
	logic               commit;
	logic               wr_en;
	entry_t             wr_data;
	logic               hdr_acc;
	res_t               res_q;
	logic               res_valid_q;

	// Select the lookup key from the incoming header
	assign rx_group = hdr.receiver_addr[GROUP_BIT];
	always_comb begin
		key_addr_d = hdr.transmitter_addr;
		key_tid_d  = '0;
		if (hdr.is_qos_data) begin
			key_tid_d = hdr.traffic_id;
			if (rx_group) begin
				key_addr_d = hdr.is_amsdu ? hdr.amsdu_dest_addr : hdr.receiver_addr;
			end
		end
	end

	assign hdr_ready = (state_q == ST_IDLE);
	assign hdr_acc   = hdr_valid && hdr_ready;

	// Capture the header and key on acceptance
	always_ff @(posedge clk) begin
		if (hdr_acc) begin
			hdr_q      <= hdr;
			key_addr_q <= key_addr_d;
			key_tid_q  <= key_tid_d;
		end
	end

	// Entry memory
	wrdf_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_idx_q),
		.rd_data  (rd_data),
		.rd_valid (rd_valid),
		.wr_en    (wr_en),
		.wr_addr  (sel_idx),
		.wr_data  (wr_data)
	);

	// Shared key comparator on the registered read data
	assign hit = rd_valid && (rd_data.is_qos == hdr_q.is_qos_data) &&
		(rd_data.addr == key_addr_q) &&
		(!hdr_q.is_qos_data || (rd_data.tid == key_tid_q));

	// Output slot is free when empty or being emptied
	assign out_free = !res_valid_q || res_ready;
	assign commit   = (state_q == ST_DECIDE) && out_free;

	// Sequencer: scan the table, then decide and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			cmp_en_s1 <= 1'b0;
		end else begin
			cmp_en_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (hdr_acc) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_LASTCMP;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_LASTCMP: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Advance the compare stage index
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q;
	end

	// Record the first matching entry and the lowest free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (hdr_acc) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmp_en_s1) begin
			if (hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (!rd_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en_s1 && hit && !found_q) begin
			match_idx_q <= cmp_idx_s1;
			hit_frag_q  <= rd_data.frag;
		end
		if (cmp_en_s1 && !rd_valid && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// Pick the entry state: stored on a match, fresh otherwise
	assign full    = !found_q && !free_found_q;
	assign sel_idx = found_q ? match_idx_q : free_idx_q;
	always_comb begin
		cur_frag.last_seq   = SEQ_FRESH;
		cur_frag.reasm      = 1'b0;
		cur_frag.frag_count = '0;
		if (found_q) begin
			cur_frag = hit_frag_q;
		end
	end

	wrdf_decide u_decide (
		.cur    (cur_frag),
		.retry  (hdr_q.retry_bit),
		.more   (hdr_q.more_fragments),
		.seq    (hdr_q.seq_control),
		.nxt    (nxt_frag),
		.action (action)
	);

	// Write back the entry, claiming it when new
	assign wr_en          = commit && !full;
	assign wr_data.is_qos = hdr_q.is_qos_data;
	assign wr_data.addr   = key_addr_q;
	assign wr_data.tid    = key_tid_q;
	assign wr_data.frag   = nxt_frag;

	assign sel_idx_ext = {4'd0, sel_idx};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q.action         <= action;
			res_q.entry_index    <= full ? '0 : sel_idx_ext[OIDX_W-1:0];
			res_q.fragment_count <= nxt_frag.frag_count;
			res_q.table_full     <= full;
			res_q.link_out       <= hdr_q.link_id;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hdl/wrdf_table.sv
// Originator table: entry memory with one registered read port and per-entry valid bits.
module wrdf_table import wrdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	output logic             rd_valid,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t                     mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]   valid_q;

	// Write and read the entry memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	// Track claimed entries; entries are never freed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid <= valid_q[rd_addr];
		end
	end

endmodule

>>> hdl/wrdf_decide.sv
// Duplicate and fragment-order decision for one frame against one entry state.
module wrdf_decide import wrdf_pkg::*; (
	input  frag_state_t      cur,
	input  logic             retry,
	input  logic             more,
	input  logic [SEQ_W-1:0] seq,
	output frag_state_t      nxt,
	output logic [ACT_W-1:0] action
);

	logic                same_seq_num;
	logic                next_frag;
	logic [FRAG_W:0]     last_frag_inc;

	// Next fragment: same sequence number, fragment number one higher
	assign same_seq_num  = seq[SEQ_W-1:FRAG_W] == cur.last_seq[SEQ_W-1:FRAG_W];
	assign last_frag_inc = {1'b0, cur.last_seq[FRAG_W-1:0]} + {{FRAG_W{1'b0}}, 1'b1};
	assign next_frag     = same_seq_num && ({1'b0, seq[FRAG_W-1:0]} == last_frag_inc);

	// Classify the frame and update the entry state
	always_comb begin
		nxt    = cur;
		action = ACT_SINGLE;
		if (retry && (cur.last_seq == seq)) begin
			action = ACT_DUP;
		end else if (cur.reasm) begin
			if (!next_frag) begin
				action = ACT_OOO;
			end else if (more) begin
				action       = ACT_MIDDLE;
				nxt.last_seq = seq;
				if (cur.frag_count < COUNT_MAX) begin
					nxt.frag_count = cur.frag_count + 5'd1;
				end
			end else begin
				action         = ACT_DONE;
				nxt.last_seq   = seq;
				nxt.reasm      = 1'b0;
				nxt.frag_count = '0;
			end
		end else if (more) begin
			action         = ACT_FIRST;
			nxt.last_seq   = seq;
			nxt.reasm      = 1'b1;
			nxt.frag_count = 5'd1;
		end else begin
			action         = ACT_SINGLE;
			nxt.last_seq   = seq;
			nxt.frag_count = '0;
		end
	end

endmodule

>>> hdl/wrdf_chk.sv
// Port-level checker for the duplicate/defrag filter, bound to the top level.
module wrdf_chk import wrdf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic hdr_valid,
	input logic hdr_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// Hold a stalled decision
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled decision changed or dropped");

	// Busy after taking a header
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && hdr_ready |=> !hdr_ready)
		else $error("header taken while a frame is in work");

	// No entry index when the table is full
	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.table_full |-> res.entry_index == '0)
		else $error("table_full with nonzero entry_index");

	// Fragment count agrees with the decision
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.action != ACT_SINGLE && res.action != ACT_DONE) ||
			res.fragment_count == '0) &&
			(res.action != ACT_FIRST || res.fragment_count == 5'd1) &&
			(res.fragment_count <= COUNT_MAX))
		else $error("fragment count inconsistent with action");

	// Decision code in range
	a_action: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.action == ACT_DUP || res.action == ACT_OOO ||
			res.action == ACT_FIRST || res.action == ACT_MIDDLE ||
			res.action == ACT_SINGLE || res.action == ACT_DONE))
		else $error("unknown action code");

endmodule

bind wlan_rx_duplicate_defrag_filter wrdf_chk u_wrdf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.hdr_valid (hdr_valid),
	.hdr_ready (hdr_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

>>> dv/tb_wlan_rx_duplicate_defrag_filter.sv
// Self-checking testbench for the 802.11 receive duplicate filter and defragmenter.
module tb_wlan_rx_duplicate_defrag_filter import wrdf_pkg::*;;

	localparam int SN_W        = SEQ_W - FRAG_W;
	localparam int HDR_TAIL_W  = $bits(hdr_t) - 3 * ADDR_W;
	localparam int FRAME_COUNT = 600;
	localparam int PHASE_SPLIT = 380;
	localparam int IDLE_LIMIT  = 3000;
	localparam int MAX_FLOWS   = 32;

	typedef enum int {FLOW_LEGACY, FLOW_QOS_UNICAST, FLOW_QOS_GROUP, FLOW_QOS_AMSDU} flow_kind_t;

	// One traffic source: its lookup key and where its sequence numbering stands
	typedef struct {
		flow_kind_t        kind;
		logic [ADDR_W-1:0] addr;
		logic [TID_W-1:0]  tid;
		logic [SN_W-1:0]   sn;
		bit                open;
		logic [SEQ_W-1:0]  resume;
	} flow_t;

	// Mirror of the originator table and the decisions still owed by the block
	class dedup_tracker;
		bit     slot_used[TABLE_ENTRIES];
		entry_t slot[TABLE_ENTRIES];
		res_t   decisions_due[$];
		int     errors;

		function void note_header(hdr_t h);
			logic [ADDR_W-1:0] key_addr;
			logic [TID_W-1:0]  key_tid;
			int                hit;
			int                spare;
			bit                full;
			bit                in_order;
			frag_state_t       st;
			logic [ACT_W-1:0]  act;
			res_t              r;

			// select the lookup key
			key_addr = h.transmitter_addr;
			key_tid  = '0;
			if (h.is_qos_data) begin
				key_tid = h.traffic_id;
				if (h.receiver_addr[GROUP_BIT])
					key_addr = h.is_amsdu ? h.amsdu_dest_addr : h.receiver_addr;
			end

			// find the first matching entry and the lowest free one
			hit   = -1;
			spare = -1;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (slot_used[i]) begin
					if (hit < 0 && slot[i].is_qos == h.is_qos_data && slot[i].addr == key_addr &&
					    (!h.is_qos_data || slot[i].tid == key_tid))
						hit = i;
				end else if (spare < 0) begin
					spare = i;
				end
			end

			// claim a fresh entry, or judge against an unstored one when the table is full
			full = 1'b0;
			if (hit < 0) begin
				if (spare >= 0) begin
					hit                  = spare;
					slot_used[hit]       = 1'b1;
					slot[hit].is_qos     = h.is_qos_data;
					slot[hit].addr       = key_addr;
					slot[hit].tid        = key_tid;
					slot[hit].frag.last_seq   = SEQ_FRESH;
					slot[hit].frag.reasm      = 1'b0;
					slot[hit].frag.frag_count = '0;
				end else begin
					full = 1'b1;
				end
			end
			if (full) begin
				st.last_seq   = SEQ_FRESH;
				st.reasm      = 1'b0;
				st.frag_count = '0;
			end else begin
				st = slot[hit].frag;
			end

			// decide and advance the reassembly state
			in_order = h.seq_control[SEQ_W-1:FRAG_W] == st.last_seq[SEQ_W-1:FRAG_W] &&
			           int'(h.seq_control[FRAG_W-1:0]) == int'(st.last_seq[FRAG_W-1:0]) + 1;
			if (h.retry_bit && st.last_seq == h.seq_control) begin
				act = ACT_DUP;
			end else if (st.reasm) begin
				if (!in_order) begin
					act = ACT_OOO;
				end else if (h.more_fragments) begin
					act         = ACT_MIDDLE;
					st.last_seq = h.seq_control;
					if (st.frag_count < COUNT_MAX)
						st.frag_count = st.frag_count + 5'd1;
				end else begin
					act           = ACT_DONE;
					st.last_seq   = h.seq_control;
					st.reasm      = 1'b0;
					st.frag_count = '0;
				end
			end else if (h.more_fragments) begin
				act           = ACT_FIRST;
				st.last_seq   = h.seq_control;
				st.reasm      = 1'b1;
				st.frag_count = 5'd1;
			end else begin
				act           = ACT_SINGLE;
				st.last_seq   = h.seq_control;
				st.frag_count = '0;
			end
			if (!full)
				slot[hit].frag = st;

			r.action         = act;
			r.entry_index    = full ? '0 : hit[OIDX_W-1:0];
			r.fragment_count = st.frag_count;
			r.table_full     = full;
			r.link_out       = h.link_id;
			decisions_due = {decisions_due, r};
		endfunction

		function void compare(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_decision(res_t got);
			res_t want;

			if (decisions_due.size() == 0) begin
				$error("decision with no frame outstanding: %p", got);
				errors++;
				return;
			end
			want = decisions_due.pop_front();
			compare("action", 8'(want.action), 8'(got.action));
			compare("entry_index", 8'(want.entry_index), 8'(got.entry_index));
			compare("fragment_count", 8'(want.fragment_count), 8'(got.fragment_count));
			compare("table_full", 8'(want.table_full), 8'(got.table_full));
			compare("link_out", 8'(want.link_out), 8'(got.link_out));
		endfunction

		function int pending();
			return decisions_due.size();
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic hdr_valid = 1'b0;
	logic hdr_ready;
	hdr_t hdr       = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	dedup_tracker tracker;
	flow_t        flows[MAX_FLOWS];
	int           flow_count  = 0;
	int           frames_sent = 0;
	bit           steady      = 1'b0;
	int           ready_hold  = 0;
	int           rx_roll;
	int           idle_cycles = 0;

	wlan_rx_duplicate_defrag_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.hdr_valid(hdr_valid),
		.hdr_ready(hdr_ready),
		.hdr(hdr),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #5 clk = ~clk;

	// Stall the decision side: mostly short gaps, now and then a long one
	always @(posedge clk) begin
		if (steady) begin
			res_ready  <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 55) begin
				res_ready  <= 1'b1;
				ready_hold <= $urandom_range(0, 20);
			end else if (rx_roll < 95) begin
				res_ready  <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else begin
				res_ready  <= 1'b0;
				ready_hold <= $urandom_range(10, 40);
			end
		end
	end

	// Record accepted headers and check accepted decisions
	always @(posedge clk) begin
		if (hdr_valid && hdr_ready)
			tracker.note_header(hdr);
		if (res_valid && res_ready)
			tracker.check_decision(res);
	end

	// Stop a hung run
	always @(posedge clk) begin
		if ((hdr_valid && hdr_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$error("no handshake for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {16'($urandom()), $urandom()};
	endfunction

	function automatic int sender_gap();
		int roll;

		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(12, 40);
	endfunction

	function automatic void add_flow(flow_kind_t kind, logic [ADDR_W-1:0] addr,
	                                 logic [TID_W-1:0] tid);
		flows[flow_count].kind = kind;
		flows[flow_count].addr = addr;
		if (kind == FLOW_QOS_GROUP)
			flows[flow_count].addr[GROUP_BIT] = 1'b1;
		flows[flow_count].tid  = tid;
		flows[flow_count].sn   = SN_W'($urandom());
		flows[flow_count].open = 1'b0;
		flow_count++;
	endfunction

	// Present one header, hold it until taken
	task automatic push_header(hdr_t h);
		int gap;

		gap = sender_gap();
		if (gap > 0) begin
			hdr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr_valid <= 1'b1;
		hdr       <= h;
		do @(posedge clk); while (!hdr_ready);
		frames_sent++;
	endtask

	// Build a header for a flow; fields outside the key, sequence and flags stay random
	task automatic send_frame(int f, logic [SEQ_W-1:0] sc, bit more, bit retry);
		hdr_t h;

		h.transmitter_addr = rand_addr();
		h.receiver_addr    = rand_addr();
		h.amsdu_dest_addr  = rand_addr();
		h.is_qos_data      = 1'b1;
		h.is_amsdu         = 1'($urandom_range(0, 1));
		h.traffic_id       = flows[f].tid;
		h.retry_bit        = retry;
		h.more_fragments   = more;
		h.seq_control      = sc;
		h.link_id          = LINK_W'($urandom());
		case (flows[f].kind)
			FLOW_LEGACY: begin
				h.is_qos_data      = 1'b0;
				h.transmitter_addr = flows[f].addr;
				h.traffic_id       = TID_W'($urandom());
			end
			FLOW_QOS_UNICAST: begin
				h.transmitter_addr         = flows[f].addr;
				h.receiver_addr[GROUP_BIT] = 1'b0;
			end
			FLOW_QOS_GROUP: begin
				h.receiver_addr = flows[f].addr;
				h.is_amsdu      = 1'b0;
			end
			default: begin
				h.receiver_addr[GROUP_BIT] = 1'b1;
				h.is_amsdu                 = 1'b1;
				h.amsdu_dest_addr          = flows[f].addr;
			end
		endcase
		push_header(h);
	endtask

	// Fully random header: new keys, random flags
	task automatic noise_header();
		hdr_t h;

		h = {rand_addr(), rand_addr(), rand_addr(), HDR_TAIL_W'($urandom())};
		if ($urandom_range(0, 9) == 0)
			h.seq_control = SEQ_FRESH;
		push_header(h);
	endtask

	// Unfragmented frame, sometimes retransmitted
	task automatic single_frame(int f);
		logic [SEQ_W-1:0] sc;

		sc = {flows[f].sn, ($urandom_range(0, 4) == 0) ? FRAG_W'($urandom()) : FRAG_W'(0)};
		send_frame(f, sc, 1'b0, $urandom_range(0, 6) == 0);
		if ($urandom_range(0, 9) < 3)
			send_frame(f, sc, 1'b0, 1'b1);
		else if ($urandom_range(0, 19) == 0)
			send_frame(f, sc, 1'b0, 1'b0);
		flows[f].sn++;
	endtask

	// Fragment burst with occasional strays, retransmissions and abandonment
	task automatic frag_burst(int f);
		int               n;
		int               first;
		int               roll;
		logic [SEQ_W-1:0] sc;
		logic [SEQ_W-1:0] stray;

		n     = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(2, 6);
		first = (n < 16 && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16 - n) : 0;
		for (int k = 0; k < n; k++) begin
			sc   = {flows[f].sn, FRAG_W'(first + k)};
			roll = $urandom_range(0, 99);
			if (roll < 4 && k > 0) begin
				// leave the entry reassembling; close it on a later visit
				flows[f].open   = 1'b1;
				flows[f].resume = sc;
				break;
			end
			if (roll < 10 && k > 0) begin
				stray                 = sc;
				stray[FRAG_W-1:0]     = sc[FRAG_W-1:0] + FRAG_W'(1);
				send_frame(f, stray, k < n - 1, 1'b0);
			end
			send_frame(f, sc, k < n - 1, $urandom_range(0, 9) == 0);
			if (roll >= 90)
				send_frame(f, sc, k < n - 1, 1'b1);
		end
		flows[f].sn++;
	endtask

	task automatic flow_activity(int f);
		int roll;

		if (flows[f].open) begin
			if ($urandom_range(0, 9) < 4)
				send_frame(f, {flows[f].sn, FRAG_W'($urandom())}, 1'b0, 1'b0);
			send_frame(f, flows[f].resume, 1'b0, 1'b0);
			flows[f].open = 1'b0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 45)
			single_frame(f);
		else if (roll < 85)
			frag_burst(f);
		else
			send_frame(f, SEQ_W'($urandom()), 1'b0, 1'($urandom_range(0, 1)));
	endtask

	// Drop valid and hold until every decision is back
	task automatic drain();
		hdr_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	initial begin
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: duplicates, fresh-entry retry, fragment order, key selection
		add_flow(FLOW_LEGACY, '1, 4'd0);
		add_flow(FLOW_QOS_UNICAST, '0, 4'd15);
		add_flow(FLOW_QOS_GROUP, 48'h0180_C200_0000, 4'd0);
		add_flow(FLOW_QOS_AMSDU, 48'h8000_0000_0001, 4'd7);
		add_flow(FLOW_LEGACY, '0, 4'd0);
		add_flow(FLOW_QOS_UNICAST, '0, 4'd14);
		send_frame(0, 16'h0000, 1'b0, 1'b0);
		send_frame(0, 16'h0000, 1'b0, 1'b1);
		send_frame(0, 16'h0010, 1'b0, 1'b1);
		send_frame(1, SEQ_FRESH, 1'b0, 1'b1);
		send_frame(1, SEQ_FRESH, 1'b0, 1'b0);
		send_frame(3, 16'h5670, 1'b1, 1'b0);
		send_frame(3, 16'h5671, 1'b1, 1'b0);
		send_frame(3, 16'h5671, 1'b1, 1'b1);
		send_frame(3, 16'h5673, 1'b1, 1'b0);
		send_frame(3, 16'h5672, 1'b0, 1'b0);
		send_frame(3, 16'h5672, 1'b0, 1'b1);
		send_frame(4, 16'hFFF0, 1'b1, 1'b0);
		send_frame(4, 16'hFFF1, 1'b0, 1'b0);
		send_frame(5, 16'h0000, 1'b0, 1'b0);
		send_frame(2, 16'h123F, 1'b1, 1'b0);
		send_frame(2, 16'h1240, 1'b1, 1'b0);
		send_frame(2, 16'h1240, 1'b0, 1'b0);
		send_frame(2, 16'h123F, 1'b1, 1'b1);
		send_frame(0, 16'h0020, 1'b1, 1'b0);
		send_frame(0, 16'h0021, 1'b0, 1'b0);
		drain();

		// random traffic on a pool that still fits in the table
		for (int i = 0; i < 8; i++)
			add_flow(flow_kind_t'($urandom_range(0, 3)), rand_addr(), TID_W'($urandom()));
		while (frames_sent < PHASE_SPLIT) begin
			steady = frames_sent >= 150 && frames_sent < 230;
			flow_activity($urandom_range(0, flow_count - 1));
		end
		steady = 1'b0;
		drain();

		// add sources until the table overflows
		for (int i = 0; i < 6; i++)
			add_flow(flow_kind_t'($urandom_range(0, 3)), rand_addr(), TID_W'($urandom()));
		while (frames_sent < FRAME_COUNT) begin
			if ($urandom_range(0, 9) == 0)
				noise_header();
			else
				flow_activity($urandom_range(0, flow_count - 1));
		end
		drain();
		repeat (TABLE_ENTRIES + 8) @(posedge clk);

		if (tracker.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
